// ----- src/dlsp_pkg.sv -----
// Shared types, codes and constants of the dual line-sensor poller.
`timescale 1ns / 1ps

package dlsp_pkg;

	// Channels on each sensor module and the width of the millisecond timestamp.
	localparam int CHANNELS_PER_MODULE = 8;
	localparam int TIME_W              = 32;

	// Widths of the stream beats.
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	// Configuration port address width and register indexes.
	localparam int CFG_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_LEFT_ADDRESS     = 3'd0,
		REG_RIGHT_ADDRESS    = 3'd1,
		REG_DIGITAL_REGISTER = 3'd2,
		REG_FRAME_PERIOD     = 3'd3,
		REG_REGISTER_WAIT    = 3'd4,
		REG_STAGE_TIMEOUT    = 3'd5
	} reg_index_t;

	// Poll status codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BUSY = 2'd1,
		ST_ERR  = 2'd2
	} poll_status_t;

	// Controller command codes.
	typedef enum logic [2:0] {
		CMD_NONE     = 3'd0,
		CMD_START_WR = 3'd1,
		CMD_PUSH     = 3'd2,
		CMD_START_RD = 3'd3,
		CMD_POP      = 3'd4,
		CMD_RECOVER  = 3'd5
	} bus_command_t;

	// Sequencer steps, one-hot.
	typedef enum logic [14:0] {
		S_IDLE       = 15'b000000000000001,
		S_L_TX_START = 15'b000000000000010,
		S_L_TX_DATA  = 15'b000000000000100,
		S_L_TX_IDLE  = 15'b000000000001000,
		S_L_WAIT_REG = 15'b000000000010000,
		S_L_RX_START = 15'b000000000100000,
		S_L_RX_DATA  = 15'b000000001000000,
		S_L_RX_IDLE  = 15'b000000010000000,
		S_R_TX_START = 15'b000000100000000,
		S_R_TX_DATA  = 15'b000001000000000,
		S_R_TX_IDLE  = 15'b000010000000000,
		S_R_WAIT_REG = 15'b000100000000000,
		S_R_RX_START = 15'b001000000000000,
		S_R_RX_DATA  = 15'b010000000000000,
		S_R_RX_IDLE  = 15'b100000000000000
	} step_t;

	// Configuration register set.
	typedef struct packed {
		logic [6:0]  left_address;
		logic [6:0]  right_address;
		logic [7:0]  digital_register;
		logic [15:0] frame_period_ms;
		logic [15:0] register_wait_ms;
		logic [15:0] stage_timeout_ms;
	} cfg_t;

	// One tick: time and controller status snapshot.
	typedef struct packed {
		logic [7:0]        rx_head;
		logic              rx_ready;
		logic              tx_room;
		logic              bus_error;
		logic              bus_busy;
		logic [TIME_W-1:0] now_ms;
	} item_t;

	// One result of a tick.
	typedef struct packed {
		logic         flags_updated;
		logic [15:0]  line_flags;
		logic [7:0]   push_byte;
		logic [6:0]   bus_target;
		bus_command_t bus_command;
		poll_status_t poll_status;
	} result_t;

	// Inverts the used channels of one module byte; unused channels read as zero.
	function automatic logic [7:0] invert_channels(input logic [7:0] b);
		logic [7:0] f;
		f = '0;
		for (int i = 0; i < 8; i++) begin
			f[i] = (i < CHANNELS_PER_MODULE) && !b[i];
		end
		return f;
	endfunction

endpackage

// ----- src/dlsp_cfg_regs.sv -----
// APB configuration registers of the dual line-sensor poller.
`timescale 1ns / 1ps

module dlsp_cfg_regs
	import dlsp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	reg_index_t idx;
	logic       wr_en;

	assign pready = 1'b1;
	assign idx    = reg_index_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// Register writes; values are masked to the register width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_address     <= 7'd76;
			cfg_q.right_address    <= 7'd77;
			cfg_q.digital_register <= 8'd0;
			cfg_q.frame_period_ms  <= 16'd10;
			cfg_q.register_wait_ms <= 16'd1;
			cfg_q.stage_timeout_ms <= 16'd3;
		end else if (wr_en) begin
			case (idx)
				REG_LEFT_ADDRESS:     cfg_q.left_address     <= pwdata[6:0];
				REG_RIGHT_ADDRESS:    cfg_q.right_address    <= pwdata[6:0];
				REG_DIGITAL_REGISTER: cfg_q.digital_register <= pwdata[7:0];
				REG_FRAME_PERIOD:     cfg_q.frame_period_ms  <= pwdata[15:0];
				REG_REGISTER_WAIT:    cfg_q.register_wait_ms <= pwdata[15:0];
				REG_STAGE_TIMEOUT:    cfg_q.stage_timeout_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		case (idx)
			REG_LEFT_ADDRESS:     prdata = {25'd0, cfg_q.left_address};
			REG_RIGHT_ADDRESS:    prdata = {25'd0, cfg_q.right_address};
			REG_DIGITAL_REGISTER: prdata = {24'd0, cfg_q.digital_register};
			REG_FRAME_PERIOD:     prdata = {16'd0, cfg_q.frame_period_ms};
			REG_REGISTER_WAIT:    prdata = {16'd0, cfg_q.register_wait_ms};
			REG_STAGE_TIMEOUT:    prdata = {16'd0, cfg_q.stage_timeout_ms};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

// ----- src/dlsp_seq_core.sv -----
// Poll sequencer state and the per-tick transition logic.
`timescale 1ns / 1ps

module dlsp_seq_core
	import dlsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    commit,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	step_t             step_q, step_n;
	logic              ever_q, ever_n;
	poll_status_t      last_q, last_n;
	logic [7:0]        left_q, left_n;
	logic [7:0]        right_q, right_n;
	logic [TIME_W-1:0] fs_q, fs_n;
	logic [TIME_W-1:0] ss_q, ss_n;
	logic [15:0]       flag_q, flag_n;

	logic [TIME_W-1:0] frame_diff, stage_diff;
	logic              frame_el_q, stage_el_q, wait_el;
	logic              starting, frame_el, stage_el;
	logic              hold, cond, ok, fail;
	step_t             step_c;

	// Next step along the frame.
	function automatic step_t next_step(input step_t s);
		case (s)
			S_L_TX_START: return S_L_TX_DATA;
			S_L_TX_DATA:  return S_L_TX_IDLE;
			S_L_TX_IDLE:  return S_L_WAIT_REG;
			S_L_WAIT_REG: return S_L_RX_START;
			S_L_RX_START: return S_L_RX_DATA;
			S_L_RX_DATA:  return S_L_RX_IDLE;
			S_L_RX_IDLE:  return S_R_TX_START;
			S_R_TX_START: return S_R_TX_DATA;
			S_R_TX_DATA:  return S_R_TX_IDLE;
			S_R_TX_IDLE:  return S_R_WAIT_REG;
			S_R_WAIT_REG: return S_R_RX_START;
			S_R_RX_START: return S_R_RX_DATA;
			S_R_RX_DATA:  return S_R_RX_IDLE;
			default:      return S_IDLE;
		endcase
	endfunction

	// Elapsed-time compares, modulo the timestamp width.
	assign frame_diff = item.now_ms - fs_q;
	assign stage_diff = item.now_ms - ss_q;
	assign frame_el_q = frame_diff >= {{(TIME_W-16){1'b0}}, cfg.frame_period_ms};
	assign stage_el_q = stage_diff >= {{(TIME_W-16){1'b0}}, cfg.stage_timeout_ms};
	assign wait_el    = stage_diff >= {{(TIME_W-16){1'b0}}, cfg.register_wait_ms};

	// A frame that starts on this tick sees zero elapsed time.
	assign starting = (step_q == S_IDLE) && !(ever_q && !frame_el_q);
	assign frame_el = starting ? (cfg.frame_period_ms == 16'd0) : frame_el_q;
	assign stage_el = starting ? (cfg.stage_timeout_ms == 16'd0) : stage_el_q;

	// Transition for one tick.
	always_comb begin
		step_n = step_q;
		ever_n = ever_q;
		last_n = last_q;
		left_n = left_q;
		right_n = right_q;
		fs_n = fs_q;
		ss_n = ss_q;
		flag_n = flag_q;
		step_c = step_q;
		hold = 1'b0;
		cond = 1'b0;
		fail = 1'b0;
		ok = 1'b0;

		result.poll_status = ST_BUSY;
		result.bus_command = CMD_NONE;
		result.bus_target = 7'd0;
		result.push_byte = 8'd0;
		result.flags_updated = 1'b0;

		// Idle: wait for the frame period (the first frame opens at once), then open a new frame.
		if (step_q == S_IDLE) begin
			if (!starting) begin
				hold = 1'b1;
				result.poll_status = last_q;
			end else begin
				ever_n = 1'b1;
				fs_n = item.now_ms;
				ss_n = item.now_ms;
				last_n = ST_BUSY;
				step_c = S_L_TX_START;
				step_n = S_L_TX_START;
			end
		end

		// Condition each waiting step looks for.
		case (step_c)
			S_L_TX_DATA, S_R_TX_DATA: cond = item.tx_room;
			S_L_RX_DATA, S_R_RX_DATA: cond = item.rx_ready;
			default:                  cond = !item.bus_busy;
		endcase

		if (!hold) begin
			if (frame_el) begin
				fail = 1'b1;
			end else begin
				ok = !item.bus_error && cond;
				case (step_c)
					S_L_TX_START, S_R_TX_START, S_L_RX_START, S_R_RX_START: begin
						fail = !ok && (item.bus_error || stage_el);
						if (ok) begin
							result.bus_command =
								((step_c == S_L_RX_START) || (step_c == S_R_RX_START)) ?
								CMD_START_RD : CMD_START_WR;
							result.bus_target =
								((step_c == S_R_TX_START) || (step_c == S_R_RX_START)) ?
								cfg.right_address : cfg.left_address;
							ss_n = item.now_ms;
							step_n = next_step(step_c);
						end
					end
					S_L_TX_DATA, S_R_TX_DATA: begin
						fail = !ok && (item.bus_error || stage_el);
						if (ok) begin
							result.bus_command = CMD_PUSH;
							result.push_byte = cfg.digital_register;
							ss_n = item.now_ms;
							step_n = next_step(step_c);
						end
					end
					S_L_TX_IDLE, S_R_TX_IDLE, S_L_RX_IDLE: begin
						fail = !ok && (item.bus_error || stage_el);
						if (ok) begin
							ss_n = item.now_ms;
							step_n = next_step(step_c);
						end
					end
					S_L_WAIT_REG, S_R_WAIT_REG: begin
						if (wait_el) begin
							ss_n = item.now_ms;
							step_n = next_step(step_c);
						end
					end
					S_L_RX_DATA, S_R_RX_DATA: begin
						fail = !ok && (item.bus_error || stage_el);
						if (ok) begin
							result.bus_command = CMD_POP;
							if (step_c == S_R_RX_DATA) begin
								right_n = item.rx_head;
							end else begin
								left_n = item.rx_head;
							end
							ss_n = item.now_ms;
							step_n = next_step(step_c);
						end
					end
					S_R_RX_IDLE: begin
						fail = !ok && (item.bus_error || stage_el);
						if (ok) begin
							flag_n = {8'd0, invert_channels(left_q)} |
								({8'd0, invert_channels(right_q)} << CHANNELS_PER_MODULE);
							step_n = S_IDLE;
							last_n = ST_OK;
							result.poll_status = ST_OK;
							result.flags_updated = 1'b1;
						end
					end
					default: begin
						step_n = S_IDLE;
						result.poll_status = last_q;
					end
				endcase
			end

			// Bus error or timeout: recover and end the frame.
			if (fail) begin
				step_n = S_IDLE;
				fs_n = item.now_ms;
				ss_n = item.now_ms;
				last_n = ST_ERR;
				result.poll_status = ST_ERR;
				result.bus_command = CMD_RECOVER;
			end
		end

		result.line_flags = flag_n;
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
			ever_q <= 1'b0;
			last_q <= ST_BUSY;
			left_q <= 8'd0;
			right_q <= 8'd0;
			fs_q <= '0;
			ss_q <= '0;
			flag_q <= 16'd0;
		end else if (commit) begin
			step_q <= step_n;
			ever_q <= ever_n;
			last_q <= last_n;
			left_q <= left_n;
			right_q <= right_n;
			fs_q <= fs_n;
			ss_q <= ss_n;
			flag_q <= flag_n;
		end
	end

endmodule

// ----- src/dual_i2c_line_sensor_poller.sv -----
// Top level of the dual line-sensor poller: stream channels, input and result registers.
//
// Usage: each input beat on the s_ channel is one tick, carrying the current
// millisecond time and a snapshot of the I2C controller status. For every beat
// the block returns exactly one result beat on the m_ channel, carrying the
// poll status, at most one controller command with its target or byte, the
// latched line flags and a flag that marks the tick that completed a frame.
// The APB port holds the module addresses, the register byte and the timing
// limits; write it only while no beat is in flight.
// Path: an accepted beat is registered in the input register, passes the
// sequencer logic and is registered in the result register; a low m_tready
// can hold it in either register.
// Throughput: one beat per cycle while m_tready is high; the sequencer state
// update is combinational subtract-compare and step selection between the
// input register and the result register.
// Reset: arst_n clears the sequencer to idle with busy status and zero flags,
// loads the register reset values and empties both registers.
// Stalls: when m_tready is low the result beat holds; one more beat waits in
// the input register, after which s_tready drops until the result is taken.
`timescale 1ns / 1ps

module dual_i2c_line_sensor_poller
	import dlsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// now_ms[31:0], bus_busy[32], bus_error[33], tx_room[34], rx_ready[35],
	// rx_head[43:36], zero fill[47:44]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// poll_status[1:0], bus_command[4:2], bus_target[11:5], push_byte[19:12],
	// line_flags[35:20], flags_updated[36], zero fill[39:37]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    adv;
	result_t res;
	result_t res_q;
	logic    m_valid_q;

	dlsp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The input beat moves on when the result register is free or being drained.
	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'(s_tdata[43:0]);
		end
	end

	dlsp_seq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'd0, res_q};

endmodule
